// ===== sv/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/ape_pkg.sv =====
package ape_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned AmtWidth  = 8;

   typedef enum logic [3:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } opcode_type;

   typedef enum logic [3:0] {
      CC_EQ = 4'd0,
      CC_NE = 4'd1,
      CC_CS = 4'd2,
      CC_CC = 4'd3,
      CC_MI = 4'd4,
      CC_PL = 4'd5,
      CC_VS = 4'd6,
      CC_VC = 4'd7,
      CC_HI = 4'd8,
      CC_LS = 4'd9,
      CC_GE = 4'd10,
      CC_LT = 4'd11,
      CC_GT = 4'd12,
      CC_LE = 4'd13,
      CC_AL = 4'd14,
      CC_NV = 4'd15
   } cond_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_type;

   // control that travels alongside each item
   typedef struct packed {
      logic       valid;
      logic       exec;
      opcode_type opcode;
      logic       s_bit;
      logic [3:0] rd;
      logic [3:0] flags;
   } ctl_type;

endpackage

// ===== sv/ape_decode.sv =====
module ape_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [ape_pkg::WordWidth-1:0]       instruction,
   input  logic [ape_pkg::WordWidth-1:0]       rn_value,
   input  logic [ape_pkg::WordWidth-1:0]       rm_value,
   input  logic [ape_pkg::WordWidth-1:0]       rs_value,
   input  logic [3:0]                          flags_in,
   output ape_pkg::ctl_type                    ctl,
   output logic [ape_pkg::WordWidth-1:0]       rn,
   output logic [ape_pkg::WordWidth-1:0]       shift_src,
   output ape_pkg::shift_type                  shift_kind,
   output logic [ape_pkg::AmtWidth-1:0]        shift_amt
);

   logic                              cond_ok;
   logic                              fn, fz, fc, fv;
   logic                              valid_ff;
   ape_pkg::ctl_type                  ctl_in;
   ape_pkg::ctl_type                  ctl_ff;
   logic [ape_pkg::WordWidth-1:0]     rn_ff;
   logic [ape_pkg::WordWidth-1:0]     src_in, src_ff;
   ape_pkg::shift_type                kind_in, kind_ff;
   logic [ape_pkg::AmtWidth-1:0]      amt_in, amt_ff;

   assign fn = flags_in[3];
   assign fz = flags_in[2];
   assign fc = flags_in[1];
   assign fv = flags_in[0];

   always_comb begin
      unique case (ape_pkg::cond_type'(instruction[31:28]))
         ape_pkg::CC_EQ: cond_ok = fz;
         ape_pkg::CC_NE: cond_ok = !fz;
         ape_pkg::CC_CS: cond_ok = fc;
         ape_pkg::CC_CC: cond_ok = !fc;
         ape_pkg::CC_MI: cond_ok = fn;
         ape_pkg::CC_PL: cond_ok = !fn;
         ape_pkg::CC_VS: cond_ok = fv;
         ape_pkg::CC_VC: cond_ok = !fv;
         ape_pkg::CC_HI: cond_ok = fc && !fz;
         ape_pkg::CC_LS: cond_ok = !fc || fz;
         ape_pkg::CC_GE: cond_ok = (fn == fv);
         ape_pkg::CC_LT: cond_ok = (fn != fv);
         ape_pkg::CC_GT: cond_ok = !fz && (fn == fv);
         ape_pkg::CC_LE: cond_ok = fz || (fn != fv);
         ape_pkg::CC_AL: cond_ok = 1'b1;
         default:        cond_ok = 1'b0;
      endcase
   end

   // immediate operand is a rotate of the 8-bit field by twice its rotate field
   always_comb begin
      if (instruction[25]) begin
         src_in  = {{(ape_pkg::WordWidth-8){1'b0}}, instruction[7:0]};
         kind_in = ape_pkg::SH_ROR;
         amt_in  = {{(ape_pkg::AmtWidth-5){1'b0}}, instruction[11:8], 1'b0};
      end else begin
         src_in  = rm_value;
         kind_in = ape_pkg::shift_type'(instruction[6:5]);
         if (instruction[4]) begin
            amt_in = rs_value[ape_pkg::AmtWidth-1:0];
         end else begin
            amt_in = {{(ape_pkg::AmtWidth-5){1'b0}}, instruction[11:7]};
         end
      end
      ctl_in.valid  = 1'b1;
      ctl_in.exec   = cond_ok;
      ctl_in.opcode = ape_pkg::opcode_type'(instruction[24:21]);
      ctl_in.s_bit  = instruction[20];
      ctl_in.rd     = instruction[15:12];
      ctl_in.flags  = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff  <= ctl_in;
         rn_ff   <= rn_value;
         src_ff  <= src_in;
         kind_ff <= kind_in;
         amt_ff  <= amt_in;
      end
   end

   always_comb begin
      ctl       = ctl_ff;
      ctl.valid = valid_ff;
   end

   assign rn         = rn_ff;
   assign shift_src  = src_ff;
   assign shift_kind = kind_ff;
   assign shift_amt  = amt_ff;

endmodule

// ===== sv/ape_shift.sv =====
module ape_shift (
   input  logic                                clock,
   input  logic                                reset,
   input  ape_pkg::ctl_type                    ctl_i,
   input  logic [ape_pkg::WordWidth-1:0]       rn_i,
   input  logic [ape_pkg::WordWidth-1:0]       shift_src,
   input  ape_pkg::shift_type                  shift_kind,
   input  logic [ape_pkg::AmtWidth-1:0]        shift_amt,
   output ape_pkg::ctl_type                    ctl_o,
   output logic [ape_pkg::WordWidth-1:0]       rn_o,
   output logic [ape_pkg::WordWidth-1:0]       op2,
   output logic                                op2_carry
);

   localparam int unsigned W = ape_pkg::WordWidth;

   logic [4:0]        amt5;
   logic              amt_zero, amt_eq32, amt_big;
   logic              sign;
   logic [W:0]        lsl_ext, lsr_ext, asr_ext;
   logic [2*W-1:0]    ror_ext;
   logic [W-1:0]      res_in;
   logic              carry_in;
   logic              valid_ff;
   ape_pkg::ctl_type  ctl_ff;
   logic [W-1:0]      rn_ff, op2_ff;
   logic              carry_ff;

   assign amt5     = shift_amt[4:0];
   assign amt_zero = (shift_amt == '0);
   assign amt_eq32 = (shift_amt == ape_pkg::AmtWidth'(W));
   assign amt_big  = (shift_amt >= ape_pkg::AmtWidth'(W));
   assign sign     = shift_src[W-1];

   assign lsl_ext = {1'b0, shift_src} << amt5;
   assign lsr_ext = {shift_src, 1'b0} >> amt5;
   assign asr_ext = $unsigned($signed({shift_src, 1'b0}) >>> amt5);
   assign ror_ext = {shift_src, shift_src} >> amt5;

   always_comb begin
      res_in   = shift_src;
      carry_in = 1'b0;
      if (!amt_zero) begin
         case (shift_kind)
            ape_pkg::SH_LSL: begin
               if (amt_big) begin
                  res_in   = '0;
                  carry_in = amt_eq32 & shift_src[0];
               end else begin
                  res_in   = lsl_ext[W-1:0];
                  carry_in = lsl_ext[W];
               end
            end
            ape_pkg::SH_LSR: begin
               if (amt_big) begin
                  res_in   = '0;
                  carry_in = amt_eq32 & sign;
               end else begin
                  res_in   = lsr_ext[W:1];
                  carry_in = lsr_ext[0];
               end
            end
            ape_pkg::SH_ASR: begin
               if (amt_big) begin
                  res_in   = {W{sign}};
                  carry_in = sign;
               end else begin
                  res_in   = asr_ext[W:1];
                  carry_in = asr_ext[0];
               end
            end
            default: begin
               res_in   = ror_ext[W-1:0];
               carry_in = ror_ext[W-1];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_i.valid) begin
         ctl_ff   <= ctl_i;
         rn_ff    <= rn_i;
         op2_ff   <= res_in;
         carry_ff <= carry_in;
      end
   end

   always_comb begin
      ctl_o       = ctl_ff;
      ctl_o.valid = valid_ff;
   end

   assign rn_o      = rn_ff;
   assign op2       = op2_ff;
   assign op2_carry = carry_ff;

endmodule

// ===== sv/ape_alu.sv =====
module ape_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  ape_pkg::ctl_type                    ctl_i,
   input  logic [ape_pkg::WordWidth-1:0]       rn,
   input  logic [ape_pkg::WordWidth-1:0]       op2,
   input  logic                                op2_carry,
   output logic                                strobe,
   output logic                                executed,
   output logic                                reg_write,
   output logic [3:0]                          dest_reg,
   output logic [ape_pkg::WordWidth-1:0]       result_value,
   output logic                                flags_write,
   output logic [3:0]                          flags_out
);

   localparam int unsigned W = ape_pkg::WordWidth;

   logic [W:0]    sum, diff, rdiff;
   logic [W-1:0]  res_in;
   logic          carry, known, wr_in, fw_in;
   logic [3:0]    fout_in;
   logic          strobe_ff, exec_ff, wr_ff, fw_ff;
   logic [3:0]    rd_ff, fout_ff;
   logic [W-1:0]  res_ff;

   assign sum   = {1'b0, rn} + {1'b0, op2};
   assign diff  = {1'b0, rn} - {1'b0, op2};
   assign rdiff = {1'b0, op2} - {1'b0, rn};

   always_comb begin
      res_in = '0;
      carry  = op2_carry;
      known  = 1'b1;
      wr_in  = 1'b0;
      case (ctl_i.opcode)
         ape_pkg::OP_AND, ape_pkg::OP_TST: begin
            res_in = rn & op2;
            wr_in  = (ctl_i.opcode == ape_pkg::OP_AND);
         end
         ape_pkg::OP_EOR, ape_pkg::OP_TEQ: begin
            res_in = rn ^ op2;
            wr_in  = (ctl_i.opcode == ape_pkg::OP_EOR);
         end
         ape_pkg::OP_ORR: begin
            res_in = rn | op2;
            wr_in  = 1'b1;
         end
         ape_pkg::OP_MOV: begin
            res_in = op2;
            wr_in  = 1'b1;
         end
         ape_pkg::OP_ADD: begin
            res_in = sum[W-1:0];
            carry  = sum[W];
            wr_in  = 1'b1;
         end
         ape_pkg::OP_SUB, ape_pkg::OP_CMP: begin
            res_in = diff[W-1:0];
            carry  = !diff[W];
            wr_in  = (ctl_i.opcode == ape_pkg::OP_SUB);
         end
         ape_pkg::OP_RSB: begin
            res_in = rdiff[W-1:0];
            carry  = !rdiff[W];
            wr_in  = 1'b1;
         end
         default: begin
            known = 1'b0;
         end
      endcase
      if (!ctl_i.exec) begin
         res_in = '0;
         known  = 1'b0;
         wr_in  = 1'b0;
      end
      fw_in   = known & ctl_i.s_bit;
      fout_in = ctl_i.flags;
      if (fw_in) begin
         fout_in = {res_in[W-1], (res_in == '0), carry, ctl_i.flags[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_i.valid) begin
         exec_ff <= ctl_i.exec;
         wr_ff   <= wr_in;
         rd_ff   <= ctl_i.rd;
         res_ff  <= res_in;
         fw_ff   <= fw_in;
         fout_ff <= fout_in;
      end
   end

   assign strobe       = strobe_ff;
   assign executed     = exec_ff;
   assign reg_write    = wr_ff;
   assign dest_reg     = rd_ff;
   assign result_value = res_ff;
   assign flags_write  = fw_ff;
   assign flags_out    = fout_ff;

endmodule

// ===== sv/arm_data_processing_execute.sv =====
// Data-processing execute unit: condition check, barrel-shifted operand 2 and
// ALU in three register stages (decode, shift, ALU). One item is taken every
// cycle that start is high outside reset; its result is driven on the rsp_
// ports, with rsp_strobe high for one cycle, once it has passed the decode,
// shift and ALU registers. There is no back-pressure: the receiver must take
// each result in the cycle it is shown. busy is high only while reset is held.
`include "assert_macros.svh"

module arm_data_processing_execute (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ape_pkg::WordWidth-1:0]       req_instruction,
   input  logic [ape_pkg::WordWidth-1:0]       req_rn_value,
   input  logic [ape_pkg::WordWidth-1:0]       req_rm_value,
   input  logic [ape_pkg::WordWidth-1:0]       req_rs_value,
   input  logic [3:0]                          req_flags_in,
   output logic                                rsp_strobe,
   output logic                                rsp_executed,
   output logic                                rsp_reg_write,
   output logic [3:0]                          rsp_dest_reg,
   output logic [ape_pkg::WordWidth-1:0]       rsp_result_value,
   output logic                                rsp_flags_write,
   output logic [3:0]                          rsp_flags_out
);

   logic                              accept;
   ape_pkg::ctl_type                  dec_ctl, sh_ctl;
   logic [ape_pkg::WordWidth-1:0]     dec_rn, dec_src, sh_rn, sh_op2;
   ape_pkg::shift_type                dec_kind;
   logic [ape_pkg::AmtWidth-1:0]      dec_amt;
   logic                              sh_carry;

   assign busy   = reset;
   assign accept = start && !busy;

   ape_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .instruction (req_instruction),
      .rn_value    (req_rn_value),
      .rm_value    (req_rm_value),
      .rs_value    (req_rs_value),
      .flags_in    (req_flags_in),
      .ctl         (dec_ctl),
      .rn          (dec_rn),
      .shift_src   (dec_src),
      .shift_kind  (dec_kind),
      .shift_amt   (dec_amt)
   );

   ape_shift u_shift (
      .clock      (clock),
      .reset      (reset),
      .ctl_i      (dec_ctl),
      .rn_i       (dec_rn),
      .shift_src  (dec_src),
      .shift_kind (dec_kind),
      .shift_amt  (dec_amt),
      .ctl_o      (sh_ctl),
      .rn_o       (sh_rn),
      .op2        (sh_op2),
      .op2_carry  (sh_carry)
   );

   ape_alu u_alu (
      .clock        (clock),
      .reset        (reset),
      .ctl_i        (sh_ctl),
      .rn           (sh_rn),
      .op2          (sh_op2),
      .op2_carry    (sh_carry),
      .strobe       (rsp_strobe),
      .executed     (rsp_executed),
      .reg_write    (rsp_reg_write),
      .dest_reg     (rsp_dest_reg),
      .result_value (rsp_result_value),
      .flags_write  (rsp_flags_write),
      .flags_out    (rsp_flags_out)
   );

   `ASSERT_IMPL(a_latency, clock, reset, accept, ##3 rsp_strobe)
   `ASSERT_IMPL(a_v_kept, clock, reset, accept, ##3 (rsp_flags_out[0] == $past(req_flags_in[0], 3)))
   `ASSERT_IMPL(a_skip_quiet, clock, reset, rsp_strobe && !rsp_executed, !rsp_reg_write && !rsp_flags_write && (rsp_result_value == '0))
   `ASSERT_IMPL(a_z_flag, clock, reset, rsp_strobe && rsp_flags_write, rsp_flags_out[2] == (rsp_result_value == '0))
   `ASSERT_PROP(a_no_phantom, clock, reset, rsp_strobe |-> $past(dec_ctl.valid, 2))

endmodule

// ===== verif/ape_scoreboard_pkg.sv =====
package ape_scoreboard_pkg;
   import ape_pkg::*;

   typedef struct packed {
      logic        executed;
      logic        reg_write;
      logic [3:0]  dest_reg;
      logic [31:0] result_value;
      logic        flags_write;
      logic [3:0]  flags_out;
   } dp_result_t;

   function automatic logic cond_passes(cond_type cc, logic [3:0] f);
      logic n, z, c, v;
      n = f[3];
      z = f[2];
      c = f[1];
      v = f[0];
      case (cc)
         CC_EQ: return z;
         CC_NE: return !z;
         CC_CS: return c;
         CC_CC: return !c;
         CC_MI: return n;
         CC_PL: return !n;
         CC_VS: return v;
         CC_VC: return !v;
         CC_HI: return c && !z;
         CC_LS: return !c || z;
         CC_GE: return n == v;
         CC_LT: return n != v;
         CC_GT: return !z && (n == v);
         CC_LE: return z || (n != v);
         CC_AL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [31:0] rotr(logic [31:0] x, logic [4:0] r);
      if (r == 0) return x;
      return (x >> r) | (x << (32 - int'(r)));
   endfunction

   // Rm through the barrel shifter; amounts of 32 and above per the register-shift rules
   function automatic void barrel(input logic [31:0] x, input shift_type kind,
                                  input logic [7:0] amt, output logic [31:0] value,
                                  output logic carry);
      value = x;
      carry = 1'b0;
      if (amt == 0) return;
      case (kind)
         SH_LSL: begin
            if (amt < 32) begin
               carry = x[32 - int'(amt)];
               value = x << amt;
            end else begin
               carry = (amt == 32) ? x[0] : 1'b0;
               value = '0;
            end
         end
         SH_LSR: begin
            if (amt < 32) begin
               carry = x[int'(amt) - 1];
               value = x >> amt;
            end else begin
               carry = (amt == 32) ? x[31] : 1'b0;
               value = '0;
            end
         end
         SH_ASR: begin
            if (amt < 32) begin
               carry = x[int'(amt) - 1];
               value = $signed(x) >>> amt;
            end else begin
               carry = x[31];
               value = {32{x[31]}};
            end
         end
         default: begin
            value = rotr(x, amt[4:0]);
            carry = value[31];
         end
      endcase
   endfunction

   function automatic dp_result_t predict_dp(logic [31:0] ins, logic [31:0] rn,
                                             logic [31:0] rm, logic [31:0] rs,
                                             logic [3:0] fin);
      dp_result_t r;
      logic [31:0] op2;
      logic        sc, c, known;
      logic [4:0]  rot;
      logic [7:0]  amt;
      opcode_type  op;
      r.executed     = 1'b0;
      r.reg_write    = 1'b0;
      r.dest_reg     = ins[15:12];
      r.result_value = '0;
      r.flags_write  = 1'b0;
      r.flags_out    = fin;
      if (!cond_passes(cond_type'(ins[31:28]), fin)) return r;
      r.executed = 1'b1;
      if (ins[25]) begin
         rot = {ins[11:8], 1'b0};
         op2 = rotr({24'd0, ins[7:0]}, rot);
         sc  = (rot != 0) ? op2[31] : 1'b0;
      end else begin
         amt = ins[4] ? rs[7:0] : {3'd0, ins[11:7]};
         barrel(rm, shift_type'(ins[6:5]), amt, op2, sc);
      end
      op    = opcode_type'(ins[24:21]);
      known = 1'b1;
      c     = sc;
      case (op)
         OP_AND, OP_TST: begin
            r.result_value = rn & op2;
            r.reg_write    = (op == OP_AND);
         end
         OP_EOR, OP_TEQ: begin
            r.result_value = rn ^ op2;
            r.reg_write    = (op == OP_EOR);
         end
         OP_ORR: begin
            r.result_value = rn | op2;
            r.reg_write    = 1'b1;
         end
         OP_MOV: begin
            r.result_value = op2;
            r.reg_write    = 1'b1;
         end
         OP_ADD: begin
            {c, r.result_value} = {1'b0, rn} + {1'b0, op2};
            r.reg_write = 1'b1;
         end
         OP_SUB, OP_CMP: begin
            r.result_value = rn - op2;
            c              = (rn >= op2);
            r.reg_write    = (op == OP_SUB);
         end
         OP_RSB: begin
            r.result_value = op2 - rn;
            c              = (op2 >= rn);
            r.reg_write    = 1'b1;
         end
         default: known = 1'b0;
      endcase
      if (known && ins[20]) begin
         r.flags_write = 1'b1;
         r.flags_out   = {r.result_value[31], r.result_value == 0, c, fin[0]};
      end
      return r;
   endfunction

   class ape_scoreboard;
      dp_result_t  pending_q[$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      function void note_item(logic [31:0] ins, logic [31:0] rn, logic [31:0] rm,
                              logic [31:0] rs, logic [3:0] fin);
         pending_q.push_back(predict_dp(ins, rn, rm, rs, fin));
      endfunction

      function int unsigned outstanding();
         return pending_q.size();
      endfunction

      function void compare_field(realtime stamp, string field, logic [31:0] want,
                                  logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", stamp, field, want, got);
         end
      endfunction

      function void check_result(realtime stamp, dp_result_t got);
         dp_result_t want;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual %h", stamp, got);
            return;
         end
         want = pending_q.pop_front();
         compare_field(stamp, "executed", 32'(want.executed), 32'(got.executed));
         compare_field(stamp, "reg_write", 32'(want.reg_write), 32'(got.reg_write));
         compare_field(stamp, "dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
         compare_field(stamp, "result_value", want.result_value, got.result_value);
         compare_field(stamp, "flags_write", 32'(want.flags_write), 32'(got.flags_write));
         compare_field(stamp, "flags_out", 32'(want.flags_out), 32'(got.flags_out));
      endfunction
   endclass

endpackage

// ===== verif/arm_data_processing_execute_tb.sv =====
module arm_data_processing_execute_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ape_pkg::*;
   import ape_scoreboard_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_instruction;
   logic [31:0] req_rn_value;
   logic [31:0] req_rm_value;
   logic [31:0] req_rs_value;
   logic [3:0]  req_flags_in;
   logic        rsp_strobe;
   logic        rsp_executed;
   logic        rsp_reg_write;
   logic [3:0]  rsp_dest_reg;
   logic [31:0] rsp_result_value;
   logic        rsp_flags_write;
   logic [3:0]  rsp_flags_out;

   ape_scoreboard sb;
   bit            no_idle;

   arm_data_processing_execute i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_instruction  (req_instruction),
      .req_rn_value     (req_rn_value),
      .req_rm_value     (req_rm_value),
      .req_rs_value     (req_rs_value),
      .req_flags_in     (req_flags_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_executed     (rsp_executed),
      .rsp_reg_write    (rsp_reg_write),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_result_value (rsp_result_value),
      .rsp_flags_write  (rsp_flags_write),
      .rsp_flags_out    (rsp_flags_out)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("** arm_data_processing_execute: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_item(req_instruction, req_rn_value, req_rm_value, req_rs_value, req_flags_in);
      end
      if (!reset && rsp_strobe) begin
         sb.check_result($realtime, dp_result_t'{rsp_executed, rsp_reg_write, rsp_dest_reg,
                                                 rsp_result_value, rsp_flags_write,
                                                 rsp_flags_out});
      end
   end

   function automatic logic [31:0] dp_word(cond_type cc, logic imm, opcode_type op, logic s,
                                           logic [3:0] rn, logic [3:0] rd,
                                           logic [11:0] operand2);
      return {cc, 2'b00, imm, op, s, rn, rd, operand2};
   endfunction

   task automatic send_item(input logic [31:0] ins, input logic [31:0] rn,
                            input logic [31:0] rm, input logic [31:0] rs,
                            input logic [3:0] fin);
      int unsigned gap;
      gap = $urandom_range(0, 5);
      if (gap != 0 && !no_idle) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_instruction <= ins;
      req_rn_value    <= rn;
      req_rm_value    <= rm;
      req_rs_value    <= rs;
      req_flags_in    <= fin;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      logic [7:0]  amts [16];
      logic [3:0]  k4;
      logic [31:0] rm;
      amts = '{8'd32, 8'd32, 8'd32, 8'd32, 8'd0, 8'd33, 8'd33, 8'd64,
               8'd255, 8'd255, 8'd1, 8'd31, 8'd96, 8'd0, 8'd40, 8'd8};
      // every opcode, register shifts by amounts below, at and beyond the word width
      for (int k = 0; k < 16; k++) begin
         k4 = k[3:0];
         rm = k4[0] ? 32'h8000_0001 : 32'h7FFF_FFFE;
         send_item(dp_word(CC_AL, 1'b0, opcode_type'(k4), 1'b1, k4, ~k4,
                           {4'hF, 1'b0, shift_type'(k4[1:0]), 1'b1, 4'h3}),
                   32'h1111_1111 * k, rm, {24'hABCDEF, amts[k]}, k4);
      end
      // ASR of a positive value by 255 fills with zeros
      send_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'h0, 4'h1,
                        {4'h2, 1'b0, SH_ASR, 1'b1, 4'h4}),
                32'h0, 32'h7FFF_FFFF, 32'h0000_00FF, 4'h0);
      // immediate, no rotation: carry 0
      send_item(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'h0, 4'h2, {4'h0, 8'hFF}),
                32'h0, 32'h0, 32'h0, 4'hF);
      // immediate rotated by 2
      send_item(dp_word(CC_AL, 1'b1, OP_MOV, 1'b1, 4'h0, 4'h3, {4'h1, 8'h03}),
                32'h0, 32'h0, 32'h0, 4'h0);
      // immediate shift of zero with ROR leaves the value, carry 0
      send_item(dp_word(CC_AL, 1'b0, OP_MOV, 1'b1, 4'h0, 4'h4,
                        {5'd0, SH_ROR, 1'b0, 4'h5}),
                32'h0, 32'hDEAD_BEEF, 32'h0, 4'hF);
      // equal compare
      send_item(dp_word(CC_AL, 1'b0, OP_CMP, 1'b1, 4'h5, 4'h6, {5'd0, SH_LSL, 1'b0, 4'h5}),
                32'd5, 32'd5, 32'h0, 4'h0);
      // add wraps to zero with carry
      send_item(dp_word(CC_AL, 1'b1, OP_ADD, 1'b1, 4'h7, 4'h7, {4'h0, 8'h01}),
                32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0);
      // S clear
      send_item(dp_word(CC_AL, 1'b1, OP_ADD, 1'b0, 4'h8, 4'h8, {4'h0, 8'h01}),
                32'hFFFF_FFFF, 32'h0, 32'h0, 4'h5);
      // condition fifteen never runs
      send_item(dp_word(CC_NV, 1'b1, OP_MOV, 1'b1, 4'h9, 4'h9, {4'h0, 8'h01}),
                32'h0, 32'h0, 32'h0, 4'hF);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      send_item(32'h0, 32'h0, 32'h0, 32'h0, 4'h0);
      send_item(32'h0, 32'h0, 32'h0, 32'h0, 4'h4);
   endtask

   task automatic run_random(input int unsigned count);
      logic [31:0] ins, rn, rm, rs;
      logic [3:0]  fin;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i == count / 2) drain();
         ins = $urandom;
         rn  = $urandom;
         rm  = $urandom;
         rs  = $urandom;
         fin = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 1) == 1) ins[31:28] = CC_AL;
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 4))
                  0: rs[7:0] = 8'd0;
                  1: rs[7:0] = 8'd1;
                  2: rs[7:0] = 8'd31;
                  3: rs[7:0] = 8'd32;
                  default: rs[7:0] = 8'd33;
               endcase
            end
            1: rs[7:0] = 8'($urandom_range(0, 40));
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0) rn = rm;
         case ($urandom_range(0, 15))
            0: rm = 32'h0;
            1: rm = 32'hFFFF_FFFF;
            default: ;
         endcase
         send_item(ins, rn, rm, rs, fin);
      end
   endtask

   initial begin
      sb = new();
      no_idle         = 1'b0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_instruction <= '0;
      req_rn_value    <= '0;
      req_rm_value    <= '0;
      req_rs_value    <= '0;
      req_flags_in    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(2000);
      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("** arm_data_processing_execute: PASSED **");
      end else begin
         if (sb.outstanding() != 0)
            $display("%0t ns: %0d results never arrived", $realtime, sb.outstanding());
         $display("** arm_data_processing_execute: FAILED **");
      end
      $finish;
   end

endmodule
